// ===== sv/aldim_pkg.sv =====
// Shared constants, codes and types of the ambient-light backlight dimmer.
`default_nettype none

package aldim_pkg;

    localparam int WINDOW_LEN_DEF = 100;
    localparam int SAMPLE_W       = 16;
    localparam int QUOT_W         = 16;
    localparam int RECIP_SHIFT    = 16;
    localparam int LUX_FRAC_BITS  = 8;

    localparam logic [SAMPLE_W-1:0] LUX_CLAMP = 16'd51200;
    localparam logic [7:0]          LUX_FULL  = 8'd200;
    localparam logic [9:0]          DUTY_FULL = 10'd650;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_UP   = 2'd2
    } t_ramp_dir;

    typedef struct packed {
        logic              valid;
        logic [QUOT_W-1:0] quot;
    } t_mean_beat;

endpackage

`default_nettype wire

// ===== sv/aldim_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module aldim_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/aldim_window.sv =====
// Sample window with running sum: clamps readings, replaces the oldest entry, yields sum/256.
`default_nettype none

module aldim_window import aldim_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SAMPLE_W-1:0] i_lux_sample,
    output t_mean_beat               o_mean,
    input  wire logic                i_mean_ready
);

    localparam int AW    = $clog2(WINDOW_LEN);
    localparam int SUM_W = $clog2(WINDOW_LEN * int'(LUX_CLAMP) + 1);

    logic [AW-1:0]         r_wr_pos;
    logic [WINDOW_LEN-1:0] r_filled;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_s1_valid;
    logic [SAMPLE_W-1:0]   r_s1_sample;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_s1_live;
    logic                  r_s2_valid;
    logic [QUOT_W-1:0]     r_s2_quot;

    logic [AW-1:0]         n_wr_pos;
    logic [SAMPLE_W-1:0]   n_sample;
    logic [SUM_W-1:0]      n_sum;
    logic [SAMPLE_W-1:0]   ram_rd_data;
    logic [SAMPLE_W-1:0]   old_value;
    logic                  s2_ready;
    logic                  s1_ready;
    logic                  accept;
    logic                  s1_move;

    assign s2_ready = !r_s2_valid || i_mean_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign accept   = i_valid && s1_ready;
    assign s1_move  = r_s1_valid && s2_ready;
    assign o_stall  = !s1_ready;

    assign n_sample  = (i_lux_sample > LUX_CLAMP) ? LUX_CLAMP : i_lux_sample;
    assign n_wr_pos  = (r_wr_pos == AW'(WINDOW_LEN - 1)) ? '0 : r_wr_pos + AW'(1);
    assign old_value = r_s1_live ? ram_rd_data : '0;
    assign n_sum     = r_sum - SUM_W'(old_value) + SUM_W'(r_s1_sample);

    aldim_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_sample),
        .i_rd_en   (accept),
        .i_rd_addr (r_wr_pos),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos   <= '0;
            r_filled   <= '0;
            r_sum      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_pos <= n_wr_pos;
            end
            if (s1_move) begin
                r_filled[r_s1_addr] <= 1'b1;
                r_sum               <= n_sum;
            end
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= n_sample;
            r_s1_addr   <= r_wr_pos;
            r_s1_live   <= r_filled[r_wr_pos];
        end
        if (s1_move) begin
            r_s2_quot <= QUOT_W'(n_sum >> LUX_FRAC_BITS);
        end
    end

    assign o_mean.valid = r_s2_valid;
    assign o_mean.quot  = r_s2_quot;

endmodule

`default_nettype wire

// ===== sv/aldim_scale.sv =====
// Mean division by the window length, duty mapping and ramp against the previous duty.
`default_nettype none

module aldim_scale import aldim_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mean_beat i_mean,
    output logic            o_mean_ready,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [9:0]      o_duty_value,
    output logic [9:0]      o_ramp_steps,
    output logic [1:0]      o_ramp_direction,
    output logic [7:0]      o_average_lux
);

    localparam logic [QUOT_W-1:0] RECIP   = QUOT_W'((2 ** RECIP_SHIFT) / WINDOW_LEN);
    localparam logic [QUOT_W-1:0] WIN_LEN = QUOT_W'(WINDOW_LEN);

    logic              r_s3_valid;
    logic [QUOT_W-1:0] r_s3_quot;
    logic [7:0]        r_s3_est;
    logic              r_out_valid;
    logic [9:0]        r_out_duty;
    logic [9:0]        r_out_steps;
    t_ramp_dir         r_out_dir;
    logic [7:0]        r_out_avg;
    logic [9:0]        r_prev_duty;

    logic [2*QUOT_W-1:0] recip_prod;
    logic [QUOT_W-1:0]   est_back;
    logic [QUOT_W-1:0]   remainder;
    logic [8:0]          avg_fixed;
    logic [7:0]          avg;
    logic [11:0]         scaled;
    logic [9:0]          n_duty;
    logic [9:0]          n_steps;
    t_ramp_dir           n_dir;
    logic                out_ready;
    logic                s3_ready;
    logic                out_load;

    assign out_ready    = !r_out_valid || !i_stall;
    assign s3_ready     = !r_s3_valid || out_ready;
    assign out_load     = r_s3_valid && out_ready;
    assign o_mean_ready = s3_ready;

    assign recip_prod = (2*QUOT_W)'(i_mean.quot) * (2*QUOT_W)'(RECIP);

    assign est_back  = QUOT_W'(r_s3_est) * WIN_LEN;
    assign remainder = r_s3_quot - est_back;
    assign avg_fixed = (remainder >= WIN_LEN) ? {1'b0, r_s3_est} + 9'd1 : {1'b0, r_s3_est};
    assign avg       = (avg_fixed > {1'b0, LUX_FULL}) ? LUX_FULL : avg_fixed[7:0];
    assign scaled    = (12'(avg) << 3) + (12'(avg) << 2) + 12'(avg);
    assign n_duty    = DUTY_FULL - scaled[11:2];

    always_comb begin
        if (n_duty < r_prev_duty) begin
            n_steps = r_prev_duty - n_duty;
            n_dir   = DIR_DOWN;
        end else if (n_duty > r_prev_duty) begin
            n_steps = n_duty - r_prev_duty;
            n_dir   = DIR_UP;
        end else begin
            n_steps = '0;
            n_dir   = DIR_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_duty <= DUTY_FULL;
        end else begin
            if (s3_ready) begin
                r_s3_valid <= i_mean.valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s3_valid;
            end
            if (out_load) begin
                r_prev_duty <= n_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && i_mean.valid) begin
            r_s3_quot <= i_mean.quot;
            r_s3_est  <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
        if (out_load) begin
            r_out_duty  <= n_duty;
            r_out_steps <= n_steps;
            r_out_dir   <= n_dir;
            r_out_avg   <= avg;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_duty_value     = r_out_duty;
    assign o_ramp_steps     = r_out_steps;
    assign o_ramp_direction = r_out_dir;
    assign o_average_lux    = r_out_avg;

endmodule

`default_nettype wire

// ===== sv/ambient_light_backlight_dimmer_unit.sv =====
// Top level of the ambient-light backlight dimmer.
// Input channel: i_valid, o_stall and i_lux_sample, one reading in 1/256 lux per
// transaction. Output channel: o_valid, i_stall and the duty, ramp step count, ramp
// direction and whole-lux mean, one result per accepted reading, in order.
// A transaction completes at a rising edge with valid high and stall low.
// Readings are clamped at 200 lux and kept in a window of WINDOW_LEN entries held in
// a RAM; a running sum, a reciprocal multiply with one correction step and a fixed
// 13/4 scaling give the mean and the duty.
// Throughput: one reading per cycle while the receiver does not stall, set by the
// four-register pipeline, in which the window RAM is read when a reading is accepted
// and written when that reading leaves the first stage.
// Reset clears the write position, the sum and one valid bit per window entry at once,
// so entries not yet written read as zero; the previous duty returns to 650. There is
// no clearing pass and the first reading may be taken right after reset.
// When the receiver stalls, the result register holds; earlier stages keep filling
// until they are all occupied, and only then is o_stall raised.
`default_nettype none

module ambient_light_backlight_dimmer_unit import aldim_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SAMPLE_W-1:0] i_lux_sample,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [9:0]               o_duty_value,
    output logic [9:0]               o_ramp_steps,
    output logic [1:0]               o_ramp_direction,
    output logic [7:0]               o_average_lux
);

    t_mean_beat mean;
    logic       mean_ready;

    aldim_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_lux_sample (i_lux_sample),
        .o_mean       (mean),
        .i_mean_ready (mean_ready)
    );

    aldim_scale #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mean           (mean),
        .o_mean_ready     (mean_ready),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_duty_value     (o_duty_value),
        .o_ramp_steps     (o_ramp_steps),
        .o_ramp_direction (o_ramp_direction),
        .o_average_lux    (o_average_lux)
    );

endmodule

`default_nettype wire

// ===== sv/aldim_checker.sv =====
// Port-level checker of the dimmer's results and its bind to the top level.
`default_nettype none

module aldim_checker import aldim_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [9:0]          o_duty_value,
    input wire logic [9:0]          o_ramp_steps,
    input wire logic [1:0]          o_ramp_direction,
    input wire logic [7:0]          o_average_lux
);

    logic [11:0] chk_scaled;
    logic [9:0]  chk_duty;

    assign chk_scaled = (12'(o_average_lux) << 3) + (12'(o_average_lux) << 2)
                        + 12'(o_average_lux);
    assign chk_duty   = DUTY_FULL - chk_scaled[11:2];

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_duty_value) && $stable(o_ramp_steps)
            && $stable(o_ramp_direction) && $stable(o_average_lux))
        else $error("stalled result changed");

    a_duty_follows_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_average_lux <= LUX_FULL && o_duty_value == chk_duty)
        else $error("duty does not match the reported mean");

    a_hold_means_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ramp_direction == DIR_HOLD) == (o_ramp_steps == 10'd0))
            && o_ramp_direction != 2'd3)
        else $error("ramp direction and step count disagree");

    a_input_accepted_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid) |-> !o_stall)
        else $error("input stalled while the pipeline cannot be full");

endmodule

bind ambient_light_backlight_dimmer_unit aldim_checker u_aldim_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_duty_value     (o_duty_value),
    .o_ramp_steps     (o_ramp_steps),
    .o_ramp_direction (o_ramp_direction),
    .o_average_lux    (o_average_lux)
);

`default_nettype wire
